// ===== sv/mer_pkg.sv =====
// Package for the Manchester edge-timed receiver.
// Holds the phase type, the flag and reciprocal constants, and the structs passed between blocks.
// No dependencies.
package mer_pkg;

    // Receive phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PREAMBLE = 3'd1,
        PH_FLAG     = 3'd2,
        PH_RECEIVE  = 3'd3
    } t_phase;

    localparam logic [7:0]  FLAG_PATTERN  = 8'h7E;
    // Index of the seventh counted preamble edge (count runs from zero)
    localparam logic [2:0]  PREAMBLE_LAST = 3'd6;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
    localparam logic [3:0]  FLAG_HOLD     = 4'd7;

    // Reciprocals for exact unsigned 32-bit division by 7 and by 5
    localparam logic [31:0] RECIP_7 = 32'h2492_4925;
    localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;

    // One line edge
    typedef struct packed {
        logic        edge_rising;
        logic [31:0] now_us;
    } t_edge;

    // One result
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_result;

    // Threshold computation request from the core
    typedef struct packed {
        logic        start;
        logic [31:0] sum;
    } t_thr_req;

    // Threshold unit status back to the core and top level
    typedef struct packed {
        logic        busy;
        logic [31:0] threshold;
    } t_thr_stat;

endpackage

// ===== sv/mer_edge_if.sv =====
// Channel interface for incoming line edges (valid/ready handshake).
// No dependencies.
interface mer_edge_if;
    logic        valid;
    logic        ready;
    logic        edge_rising;
    logic [31:0] now_us;

    modport source (output valid, output edge_rising, output now_us, input ready);
    modport sink   (input valid, input edge_rising, input now_us, output ready);
endinterface

// ===== sv/mer_byte_if.sv =====
// Channel interface for received bytes and end-of-frame marks (valid/ready handshake).
// No dependencies.
interface mer_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== sv/mer_thresh.sv =====
// Bit threshold unit: floor(floor(sum / 7) * 4 / 5) by reciprocal multiplication.
// Three registered steps; the first two use one multiplier each. Depends on mer_pkg.
module mer_thresh
    import mer_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_thr_req  i_req,
    output t_thr_stat o_stat
);

    logic [31:0] r_sum;
    logic [31:0] r_hi7;
    logic [31:0] r_hi5;
    logic [31:0] r_thr;
    logic [2:0]  r_vld;

    logic [63:0] prod7;
    logic [63:0] prod5;
    logic [31:0] quot7;
    logic [31:0] times4;

    // Step one: high word of sum * RECIP_7
    assign prod7 = 64'(r_sum) * 64'(RECIP_7);

    // Step two: finish the divide by 7 (33-bit reciprocal fix-up), scale by 4, divide by 5
    assign quot7  = (((r_sum - r_hi7) >> 1) + r_hi7) >> 2;
    assign times4 = {quot7[29:0], 2'b00};
    assign prod5  = 64'(times4) * 64'(RECIP_5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_thr <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_req.start};
            if (r_vld[2]) begin
                r_thr <= r_hi5 >> 2;
            end
        end
    end

    // Data stages
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sum <= i_req.sum;
        end
        if (r_vld[0]) begin
            r_hi7 <= prod7[63:32];
        end
        if (r_vld[1]) begin
            r_hi5 <= prod5[63:32];
        end
    end

    assign o_stat.busy      = |r_vld;
    assign o_stat.threshold = r_thr;

    // Only one computation in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_vld))
        else $error("threshold pipeline holds more than one request");

endmodule

// ===== sv/mer_core.sv =====
// Receiver core: phase control, preamble timing, flag hunt and byte assembly.
// Each accepted edge computes all next state combinationally, registered together. Depends on mer_pkg.
module mer_core
    import mer_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_edge     i_item,
    input  t_thr_stat i_thr,
    output t_thr_req  o_thr_req,
    output logic      o_res_valid,
    output t_result   o_res
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_interval_sum, n_interval_sum;
    logic [2:0]  r_preamble_edges, n_preamble_edges;
    logic [31:0] r_last_edge_time, n_last_edge_time;
    logic [7:0]  r_flag_window, n_flag_window;
    logic [3:0]  r_flag_bits, n_flag_bits;
    logic [7:0]  r_byte_window, n_byte_window;
    logic [3:0]  r_byte_bits, n_byte_bits;

    logic        bit_val;
    logic [31:0] delta;
    logic [31:0] sum_add;
    logic        in_preamble;
    logic        preamble_done;
    logic        bit_taken;
    logic        flag_shift;
    logic [7:0]  flag_sh;
    logic [3:0]  flag_inc;
    logic        flag_full;
    logic        flag_match;
    logic [7:0]  byte_sh;
    logic [3:0]  byte_inc;
    logic        byte_done;
    logic        closing;

    // Shared decode of the accepted edge
    always_comb begin
        bit_val       = ~i_item.edge_rising;
        delta         = i_item.now_us - r_last_edge_time;
        sum_add       = r_interval_sum + delta;
        in_preamble   = i_accept && (r_phase == PH_PREAMBLE);
        preamble_done = in_preamble && (r_preamble_edges == PREAMBLE_LAST);
        bit_taken     = i_accept && ((r_phase == PH_FLAG) || (r_phase == PH_RECEIVE))
                        && (delta > i_thr.threshold);
        // The last preamble edge is the first flag bit, into a cleared window
        flag_shift    = preamble_done || (bit_taken && (r_phase == PH_FLAG));
        flag_sh       = preamble_done ? {7'd0, bit_val} : {r_flag_window[6:0], bit_val};
        flag_inc      = r_flag_bits + 4'd1;
        flag_full     = (flag_inc == BITS_PER_BYTE);
        flag_match    = flag_full && (flag_sh == FLAG_PATTERN);
        byte_sh       = {r_byte_window[6:0], bit_val};
        byte_inc      = r_byte_bits + 4'd1;
        byte_done     = bit_taken && (r_phase == PH_RECEIVE) && (byte_inc == BITS_PER_BYTE);
        closing       = byte_done && (byte_sh == FLAG_PATTERN);
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                PH_PREAMBLE: begin
                    if (preamble_done) begin
                        n_phase = flag_match ? PH_RECEIVE : PH_FLAG;
                    end
                end
                PH_FLAG: begin
                    if (flag_shift && flag_match) begin
                        n_phase = PH_RECEIVE;
                    end
                end
                PH_RECEIVE: begin
                    if (closing) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    if (!i_item.edge_rising) begin
                        n_phase = PH_PREAMBLE;
                    end
                end
            endcase
        end
    end

    // Next timing and shift state
    always_comb begin
        n_interval_sum   = r_interval_sum;
        n_preamble_edges = r_preamble_edges;
        n_last_edge_time = r_last_edge_time;
        n_flag_window    = r_flag_window;
        n_flag_bits      = r_flag_bits;
        n_byte_window    = r_byte_window;
        n_byte_bits      = r_byte_bits;

        // Start of preamble from idle on a falling edge
        if (i_accept && (r_phase != PH_PREAMBLE) && (r_phase != PH_FLAG)
            && (r_phase != PH_RECEIVE) && !i_item.edge_rising) begin
            n_interval_sum   = '0;
            n_preamble_edges = '0;
            n_last_edge_time = i_item.now_us;
        end

        // Preamble interval accumulation
        if (in_preamble) begin
            n_interval_sum   = sum_add;
            n_last_edge_time = i_item.now_us;
            n_preamble_edges = preamble_done ? 3'd0 : r_preamble_edges + 3'd1;
        end

        if (bit_taken) begin
            n_last_edge_time = i_item.now_us;
        end

        // Sliding flag window
        if (flag_shift) begin
            n_flag_window = flag_sh;
            n_flag_bits   = (flag_full && !flag_match) ? FLAG_HOLD : flag_inc;
        end

        // Byte assembly
        if (bit_taken && (r_phase == PH_RECEIVE)) begin
            n_byte_window = byte_sh;
            n_byte_bits   = byte_done ? 4'd0 : byte_inc;
        end

        // Closing flag returns everything to the reset state
        if (closing) begin
            n_interval_sum   = '0;
            n_preamble_edges = '0;
            n_last_edge_time = '0;
            n_flag_window    = '0;
            n_flag_bits      = '0;
            n_byte_window    = '0;
            n_byte_bits      = '0;
        end
    end

    // Result and threshold request
    always_comb begin
        o_res_valid     = byte_done;
        o_res.frame_end = closing;
        o_res.data_byte = closing ? 8'd0 : byte_sh;
        o_thr_req.start = preamble_done;
        o_thr_req.sum   = sum_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_interval_sum   <= '0;
            r_preamble_edges <= '0;
            r_last_edge_time <= '0;
            r_flag_window    <= '0;
            r_flag_bits      <= '0;
            r_byte_window    <= '0;
            r_byte_bits      <= '0;
        end else begin
            r_phase          <= n_phase;
            r_interval_sum   <= n_interval_sum;
            r_preamble_edges <= n_preamble_edges;
            r_last_edge_time <= n_last_edge_time;
            r_flag_window    <= n_flag_window;
            r_flag_bits      <= n_flag_bits;
            r_byte_window    <= n_byte_window;
            r_byte_bits      <= n_byte_bits;
        end
    end

    // While hunting, the flag bit count saturates below a full byte
    a_flag_bits_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FLAG) |-> (r_flag_bits <= FLAG_HOLD))
        else $error("flag bit count ran past seven while hunting");

    // A request never lands while the threshold is still being worked out
    a_no_edge_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        preamble_done |=> i_thr.busy && !i_accept)
        else $error("edge taken before the bit threshold was ready");

endmodule

// ===== sv/mer_out_fifo.sv =====
// Two-entry result queue between the core and the output channel.
// Lets the core take a new request while a result waits. Depends on mer_pkg.
module mer_out_fifo
    import mer_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("result pushed into a full queue");

endmodule

// ===== sv/manchester_edge_timed_receiver_top.sv =====
// A result is registered into the result queue with the edge that completes it and offered from there.
// Throughput: one edge per cycle while the result queue has room; after the seventh preamble edge
// the input stalls while the two-multiplier threshold pipeline works out the bit threshold.
// A two-entry result queue keeps the input flowing while the output is held off.
// Reset (synchronous, active low) returns the receiver to idle with all counters cleared.
// Depends on mer_pkg, mer_edge_if, mer_byte_if, mer_thresh, mer_core, mer_out_fifo.
module manchester_edge_timed_receiver_top
    import mer_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mer_edge_if.sink    i_edge,
    mer_byte_if.source  o_byte
);

    t_edge     item;
    t_thr_req  thr_req;
    t_thr_stat thr_stat;
    t_result   res;
    t_result   out_data;
    logic      res_valid;
    logic      fifo_full;
    logic      accept;

    assign item.edge_rising = i_edge.edge_rising;
    assign item.now_us      = i_edge.now_us;

    // Input handshake: room for a result and no threshold computation pending
    assign i_edge.ready = !fifo_full && !thr_stat.busy;
    assign accept       = i_edge.valid && i_edge.ready;

    mer_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (item),
        .i_thr       (thr_stat),
        .o_thr_req   (thr_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mer_thresh u_thresh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (thr_req),
        .o_stat  (thr_stat)
    );

    mer_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (fifo_full),
        .o_valid (o_byte.valid),
        .i_ready (o_byte.ready),
        .o_data  (out_data)
    );

    assign o_byte.data_byte = out_data.data_byte;
    assign o_byte.frame_end = out_data.frame_end;

endmodule
